// File: hdl/sic_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection classifier package
// Shared constants, result codes and the small structs passed between the
// pipeline modules.
// ----------------------------------------------------------------------------
package sic_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int KIND_WIDTH      = 3;

   typedef logic [KIND_WIDTH-1:0] kind_type;

   localparam kind_type KIND_NONE    = 3'd0;
   localparam kind_type KIND_CROSS   = 3'd1;
   localparam kind_type KIND_OVERLAP = 3'd2;
   localparam kind_type KIND_A_START = 3'd3;
   localparam kind_type KIND_A_END   = 3'd4;
   localparam kind_type KIND_B_START = 3'd5;
   localparam kind_type KIND_B_END   = 3'd6;

   // Sign of one orientation determinant.
   typedef struct packed {
      logic zero;
      logic neg;
   } orient_type;

   // Stage load enables for an orientation unit.
   typedef struct packed {
      logic prod_en;
      logic sign_en;
   } orient_ctl_type;

   // Bounding box containment of each endpoint in the other segment's box.
   typedef struct packed {
      logic bs_in_a;
      logic be_in_a;
      logic as_in_b;
      logic ae_in_b;
   } bbox_type;

endpackage

// File: hdl/sic_if.sv
// ----------------------------------------------------------------------------
// Segment intersection classifier channels
// Valid/ready channels for the segment pair requests and the classification
// responses.
// ----------------------------------------------------------------------------
interface sic_req_if import sic_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] a_start_x;
   logic signed [COORD_WIDTH-1:0] a_start_y;
   logic signed [COORD_WIDTH-1:0] a_end_x;
   logic signed [COORD_WIDTH-1:0] a_end_y;
   logic signed [COORD_WIDTH-1:0] b_start_x;
   logic signed [COORD_WIDTH-1:0] b_start_y;
   logic signed [COORD_WIDTH-1:0] b_end_x;
   logic signed [COORD_WIDTH-1:0] b_end_y;

   modport source (
      output valid, a_start_x, a_start_y, a_end_x, a_end_y,
             b_start_x, b_start_y, b_end_x, b_end_y,
      input  ready
   );
   modport sink (
      input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
             b_start_x, b_start_y, b_end_x, b_end_y,
      output ready
   );
endinterface

interface sic_rsp_if import sic_pkg::*; ();
   logic     valid;
   logic     ready;
   kind_type meet_kind;

   modport source (output valid, meet_kind, input ready);
   modport sink (input valid, meet_kind, output ready);
endinterface

// File: hdl/sic_orient.sv
// ----------------------------------------------------------------------------
// Orientation unit
// Exact sign of a*b - c*d over two register stages: the products, then the
// difference reduced to a zero flag and a negative flag.
// ----------------------------------------------------------------------------
module sic_orient import sic_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                        clock,
   input  orient_ctl_type              ctl,
   input  logic signed [COORD_WIDTH:0] diff_a,
   input  logic signed [COORD_WIDTH:0] diff_b,
   input  logic signed [COORD_WIDTH:0] diff_c,
   input  logic signed [COORD_WIDTH:0] diff_d,
   output orient_type                  sign
);

   localparam int PW = 2 * COORD_WIDTH + 2;

   logic signed [PW-1:0] prod_ab_in, prod_ab_ff;
   logic signed [PW-1:0] prod_cd_in, prod_cd_ff;
   logic signed [PW:0]   det;
   orient_type           sign_in, sign_ff;

   assign prod_ab_in = PW'(diff_a) * PW'(diff_b);
   assign prod_cd_in = PW'(diff_c) * PW'(diff_d);

   // One extra bit keeps the difference of the two products exact.
   assign det          = (PW+1)'(prod_ab_ff) - (PW+1)'(prod_cd_ff);
   assign sign_in.zero = (det == '0);
   assign sign_in.neg  = det[PW];

   always_ff @(posedge clock) begin
      if (ctl.prod_en) begin
         prod_ab_ff <= prod_ab_in;
         prod_cd_ff <= prod_cd_in;
      end
      if (ctl.sign_en) begin
         sign_ff <= sign_in;
      end
   end

   assign sign = sign_ff;

endmodule

// File: hdl/sic_classify.sv
// ----------------------------------------------------------------------------
// Meeting classifier
// Combines the four orientation signs and the bounding box flags into the
// meeting kind and holds it in the output register.
// ----------------------------------------------------------------------------
module sic_classify import sic_pkg::*; (
   input  logic       clock,
   input  logic       load_en,
   input  orient_type o1,
   input  orient_type o2,
   input  orient_type o3,
   input  orient_type o4,
   input  bbox_type   bbox,
   output kind_type   meet_kind
);

   logic     on_bs, on_be, on_as, on_ae, proper;
   kind_type kind_in, kind_ff;

   // A collinear endpoint inside the other segment's box lies on it.
   assign on_bs = o1.zero & bbox.bs_in_a;
   assign on_be = o2.zero & bbox.be_in_a;
   assign on_as = o3.zero & bbox.as_in_b;
   assign on_ae = o4.zero & bbox.ae_in_b;

   assign proper = ~o1.zero & ~o2.zero & ~o3.zero & ~o4.zero &
                   (o1.neg ^ o2.neg) & (o3.neg ^ o4.neg);

   always_comb begin
      if (proper) begin
         kind_in = KIND_CROSS;
      end else if (on_bs) begin
         kind_in = (on_as | on_ae | on_be) ? KIND_OVERLAP : KIND_B_START;
      end else if (on_be) begin
         kind_in = (on_as | on_ae | on_bs) ? KIND_OVERLAP : KIND_B_END;
      end else if (on_as) begin
         kind_in = (on_bs | on_be | on_ae) ? KIND_OVERLAP : KIND_A_START;
      end else if (on_ae) begin
         kind_in = (on_bs | on_be | on_as) ? KIND_OVERLAP : KIND_A_END;
      end else begin
         kind_in = KIND_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         kind_ff <= kind_in;
      end
   end

   assign meet_kind = kind_ff;

endmodule

// File: hdl/segment_intersection_classifier.sv
// ----------------------------------------------------------------------------
// Segment intersection classifier
// Classifies how two integer 2D segments meet using exact orientation tests.
// ----------------------------------------------------------------------------
// The block takes one segment pair per clock cycle and returns one meeting
// kind per pair, in order, through a pipeline: one stage forms coordinate
// differences and bounding box tests, one forms the cross products, one
// reduces each determinant to its sign, and the last classifies into the
// output register. Each stage advances whenever the stage after it is empty
// or moving, so back pressure on the response channel stalls the pipeline
// without losing or repeating a transaction.
module segment_intersection_classifier import sic_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input logic       clock,
   input logic       reset,
   sic_req_if.sink   req_chan,
   sic_rsp_if.source rsp_chan
);

   localparam int DW = COORD_WIDTH + 1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DW-1:0]          diff_type;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic ready1, ready2, ready3, ready4;

   coord_type as_x, as_y, ae_x, ae_y, bs_x, bs_y, be_x, be_y;

   // diff_*[k] feeds orientation unit k as a*b - c*d.
   diff_type diff_a_in [4], diff_a_ff [4];
   diff_type diff_b_in [4], diff_b_ff [4];
   diff_type diff_c_in [4], diff_c_ff [4];
   diff_type diff_d_in [4], diff_d_ff [4];

   bbox_type       bbox_in, bbox1_ff, bbox2_ff, bbox3_ff;
   orient_ctl_type orient_ctl;
   orient_type     sign [4];

   function automatic logic in_range(coord_type q, coord_type p, coord_type r);
      return ((q >= p) && (q <= r)) || ((q >= r) && (q <= p));
   endfunction

   assign as_x = req_chan.a_start_x;
   assign as_y = req_chan.a_start_y;
   assign ae_x = req_chan.a_end_x;
   assign ae_y = req_chan.a_end_y;
   assign bs_x = req_chan.b_start_x;
   assign bs_y = req_chan.b_start_y;
   assign be_x = req_chan.b_end_x;
   assign be_y = req_chan.b_end_y;

   // Orientation of (p, q, r) is (q.y - p.y)*(r.x - q.x) - (q.x - p.x)*(r.y - q.y).
   // Unit 0: (a_start, a_end, b_start); 1: (a_start, a_end, b_end);
   // 2: (b_start, b_end, a_start); 3: (b_start, b_end, a_end).
   always_comb begin
      diff_a_in[0] = DW'(ae_y) - DW'(as_y);
      diff_b_in[0] = DW'(bs_x) - DW'(ae_x);
      diff_c_in[0] = DW'(ae_x) - DW'(as_x);
      diff_d_in[0] = DW'(bs_y) - DW'(ae_y);

      diff_a_in[1] = DW'(ae_y) - DW'(as_y);
      diff_b_in[1] = DW'(be_x) - DW'(ae_x);
      diff_c_in[1] = DW'(ae_x) - DW'(as_x);
      diff_d_in[1] = DW'(be_y) - DW'(ae_y);

      diff_a_in[2] = DW'(be_y) - DW'(bs_y);
      diff_b_in[2] = DW'(as_x) - DW'(be_x);
      diff_c_in[2] = DW'(be_x) - DW'(bs_x);
      diff_d_in[2] = DW'(as_y) - DW'(be_y);

      diff_a_in[3] = DW'(be_y) - DW'(bs_y);
      diff_b_in[3] = DW'(ae_x) - DW'(be_x);
      diff_c_in[3] = DW'(be_x) - DW'(bs_x);
      diff_d_in[3] = DW'(ae_y) - DW'(be_y);
   end

   assign bbox_in.bs_in_a = in_range(bs_x, as_x, ae_x) && in_range(bs_y, as_y, ae_y);
   assign bbox_in.be_in_a = in_range(be_x, as_x, ae_x) && in_range(be_y, as_y, ae_y);
   assign bbox_in.as_in_b = in_range(as_x, bs_x, be_x) && in_range(as_y, bs_y, be_y);
   assign bbox_in.ae_in_b = in_range(ae_x, bs_x, be_x) && in_range(ae_y, bs_y, be_y);

   // A stage may load when it is empty or its contents move on this cycle.
   assign ready4 = !v4_ff || rsp_chan.ready;
   assign ready3 = !v3_ff || ready4;
   assign ready2 = !v2_ff || ready3;
   assign ready1 = !v1_ff || ready2;

   assign req_chan.ready = ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= req_chan.valid;
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
         if (ready4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         diff_a_ff <= diff_a_in;
         diff_b_ff <= diff_b_in;
         diff_c_ff <= diff_c_in;
         diff_d_ff <= diff_d_in;
         bbox1_ff  <= bbox_in;
      end
      if (ready2) begin
         bbox2_ff <= bbox1_ff;
      end
      if (ready3) begin
         bbox3_ff <= bbox2_ff;
      end
   end

   assign orient_ctl.prod_en = ready2;
   assign orient_ctl.sign_en = ready3;

   for (genvar k = 0; k < 4; k++) begin : g_orient
      sic_orient #(
         .COORD_WIDTH (COORD_WIDTH)
      ) u_orient (
         .clock  (clock),
         .ctl    (orient_ctl),
         .diff_a (diff_a_ff[k]),
         .diff_b (diff_b_ff[k]),
         .diff_c (diff_c_ff[k]),
         .diff_d (diff_d_ff[k]),
         .sign   (sign[k])
      );
   end

   sic_classify u_classify (
      .clock     (clock),
      .load_en   (ready4),
      .o1        (sign[0]),
      .o2        (sign[1]),
      .o3        (sign[2]),
      .o4        (sign[3]),
      .bbox      (bbox3_ff),
      .meet_kind (rsp_chan.meet_kind)
   );

   assign rsp_chan.valid = v4_ff;

endmodule
